### sv/bsi_pkg.sv
// Shared types and constants for the bit-sliced index engine.
package bsi_pkg;

    localparam int ROW_ID_W   = 12;
    localparam int VALUE_W    = 64;
    localparam int WORD_IDX_W = 6;
    localparam int DEPTH_W    = 7;
    localparam int RESULT_W   = 64;

    typedef enum logic [2:0] {
        ACT_PUT       = 3'd0,
        ACT_REMOVE    = 3'd1,
        ACT_GET       = 3'd2,
        ACT_LESS      = 3'd3,
        ACT_GREATER   = 3'd4,
        ACT_EQUAL     = 3'd5,
        ACT_NOT_EQUAL = 3'd6,
        ACT_BETWEEN   = 3'd7
    } action_t;

    typedef struct packed {
        action_t                 action;
        logic [ROW_ID_W-1:0]     row_id;
        logic [VALUE_W-1:0]      value;
        logic [VALUE_W-1:0]      value_high;
        logic                    allow_equal;
        logic [WORD_IDX_W-1:0]   word_index;
        logic [RESULT_W-1:0]     filter_word;
        logic                    filter_empty;
    } req_t;

    typedef struct packed {
        logic                    found;
        logic [VALUE_W-1:0]      read_value;
        logic [RESULT_W-1:0]     result_word;
    } rsp_t;

    typedef struct packed {
        logic clr;
        logic en;
    } cmp_ctrl_t;

endpackage

### sv/bsi_cdiv.sv
// Division by a constant through reciprocal multiplication: quotient, then remainder.
module bsi_cdiv #(
    parameter int DW      = 12,
    parameter int DIVISOR = 64
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    output logic          done,
    output logic [DW-1:0] quotient,
    output logic [DW-1:0] remainder
);

    localparam int              SH  = DW + $clog2(DIVISOR);
    localparam longint unsigned MUL = ((64'd1 << SH) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
    localparam int              MW  = $clog2(MUL + 64'd1);
    localparam int              PW  = DW + MW;

    logic          mul_reg, mul_next;
    logic          sub_reg, sub_next;
    logic          done_reg, done_next;
    logic [DW-1:0] num_reg, num_next;
    logic [DW-1:0] quo_reg, quo_next;
    logic [DW-1:0] rem_reg, rem_next;
    logic [PW-1:0] product;
    logic [31:0]   back;

    assign product = PW'(num_reg) * PW'(MUL);
    assign back    = 32'(quo_reg) * 32'(DIVISOR);

    always_comb
    begin
        mul_next  = 1'b0;
        sub_next  = 1'b0;
        done_next = 1'b0;
        num_next  = num_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            mul_next = 1'b1;
            num_next = dividend;
        end
        else if (mul_reg)
        begin
            quo_next = DW'(product >> SH);
            sub_next = 1'b1;
        end
        else if (sub_reg)
        begin
            rem_next  = num_reg - DW'(back);
            done_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_reg  <= 1'b0;
            sub_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            mul_reg  <= mul_next;
            sub_reg  <= sub_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

### sv/bsi_mem.sv
// Slice store: one write port, one registered read port.
module bsi_mem #(
    parameter int DEPTH = 4160,
    parameter int AW    = 13,
    parameter int WIDTH = 64
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_array [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_array[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_array[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### sv/bsi_cmp.sv
// Per-row unsigned compare against a bound, one slice per cycle while enabled, from the low bit.
module bsi_cmp
    import bsi_pkg::*;
#(
    parameter int RPW = 64
) (
    input  logic           clk,
    input  cmp_ctrl_t      ctrl,
    input  logic [RPW-1:0] slice,
    input  logic           bound_bit,
    output logic [RPW-1:0] lt,
    output logic [RPW-1:0] gt
);

    logic [RPW-1:0] lt_reg, lt_next;
    logic [RPW-1:0] gt_reg, gt_next;
    logic [RPW-1:0] bound;
    logic [RPW-1:0] same;

    assign bound = {RPW{bound_bit}};
    assign same  = ~(slice ^ bound);

    always_comb
    begin
        lt_next = lt_reg;
        gt_next = gt_reg;
        if (ctrl.clr)
        begin
            lt_next = '0;
            gt_next = '0;
        end
        else if (ctrl.en)
        begin
            lt_next = (~slice & bound) | (same & lt_reg);
            gt_next = (slice & ~bound) | (same & gt_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        lt_reg <= lt_next;
        gt_reg <= gt_next;
    end

    assign lt = lt_reg;
    assign gt = gt_reg;

endmodule

### sv/bit_sliced_index_engine.sv
// Top level of the bit-sliced index engine: sequencer, row datapath and result register.
//
//  channel  direction  handshake             payload
//  req      in         req_valid / req_stall req_t
//  rsp      out        rsp_valid / rsp_stall rsp_t
//  cfg      in         cfg_we                cfg_data (bit_depth)
//
// A transfer passes through the row and word dividers, then takes one store read per slice
// (present slice plus bit_depth value slices) through the single read port, with
// write-back in the cycle after each read, then a drain, a result and an idle state.
// After reset a clearing pass zeroes all (MAX_VALUE_BITS+1)*ROW_COUNT/ROWS_PER_WORD
// store words (4160 by default), with req stalled. A stalled result is held while the
// next request is taken and worked on.
module bit_sliced_index_engine
    import bsi_pkg::*;
#(
    parameter int ROW_COUNT      = 4096,
    parameter int MAX_VALUE_BITS = 64,
    parameter int ROWS_PER_WORD  = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  req_t               req,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output rsp_t               rsp,
    input  logic               cfg_we,
    input  logic [DEPTH_W-1:0] cfg_data
);

    localparam int RPW    = ROWS_PER_WORD;
    localparam int MVB    = MAX_VALUE_BITS;
    localparam int WPS    = ROW_COUNT / ROWS_PER_WORD;
    localparam int DEPTH  = (MAX_VALUE_BITS + 1) * WPS;
    localparam int AW     = $clog2(DEPTH);
    localparam int RBW    = $clog2(ROWS_PER_WORD);
    localparam int DEPW   = $clog2(MAX_VALUE_BITS + 1);

    typedef enum logic [6:0] {
        ST_CLEAR = 7'b0000001,
        ST_IDLE  = 7'b0000010,
        ST_DIV_A = 7'b0000100,
        ST_DIV_B = 7'b0001000,
        ST_RUN   = 7'b0010000,
        ST_DRAIN = 7'b0100000,
        ST_FIN   = 7'b1000000
    } state_t;

    state_t          state_reg, state_next;
    logic [DEPW-1:0] depth_reg, depth_next;
    logic [AW-1:0]   clr_cnt_reg, clr_cnt_next;
    logic [DEPW-1:0] k_reg, k_next;
    logic            rd_valid_reg, rd_valid_next;
    logic            rsp_valid_reg, rsp_valid_next;

    req_t            item_reg, item_next;
    logic [AW-1:0]   addr_reg, addr_next;
    logic [AW-1:0]   wb_addr_reg, wb_addr_next;
    logic            rd_present_reg, rd_present_next;
    logic [RPW-1:0]  rmask_reg, rmask_next;
    logic [MVB-1:0]  vsh_reg, vsh_next;
    logic [MVB-1:0]  hsh_reg, hsh_next;
    logic [MVB-1:0]  pos_reg, pos_next;
    logic [MVB-1:0]  old_reg, old_next;
    logic            was_reg, was_next;
    logic [RPW-1:0]  present_reg, present_next;
    rsp_t            rsp_reg, rsp_next;

    logic                accept;
    logic                row_done, word_done, widx_done;
    logic [ROW_ID_W-1:0] row_quo, row_rem, word_quo, word_rem, widx_quo, widx_rem;
    logic [ROW_ID_W-1:0] row_word;

    logic            mem_we, mem_re;
    logic [AW-1:0]   mem_waddr, mem_raddr;
    logic [RPW-1:0]  mem_wdata, mem_rdata;

    cmp_ctrl_t       cmp_ctrl;
    logic [RPW-1:0]  lt_lo, gt_lo, lt_hi, gt_hi, eq_lo, eq_hi;
    logic [RPW-1:0]  filt, qres;
    logic            is_row_op, is_put, is_remove, slice_bit, rsp_free;

    assign accept    = req_valid && !req_stall;
    assign req_stall = (state_reg != ST_IDLE);
    assign is_put    = (item_reg.action == ACT_PUT);
    assign is_remove = (item_reg.action == ACT_REMOVE);
    assign is_row_op = (item_reg.action inside {ACT_PUT, ACT_REMOVE, ACT_GET});
    assign rsp_free  = !rsp_valid_reg || !rsp_stall;

    bsi_cdiv #(.DW(ROW_ID_W), .DIVISOR(ROW_COUNT)) u_row_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (accept),
        .dividend  (req.row_id),
        .done      (row_done),
        .quotient  (row_quo),
        .remainder (row_rem)
    );

    bsi_cdiv #(.DW(ROW_ID_W), .DIVISOR(WPS)) u_widx_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (accept),
        .dividend  (ROW_ID_W'(req.word_index)),
        .done      (widx_done),
        .quotient  (widx_quo),
        .remainder (widx_rem)
    );

    bsi_cdiv #(.DW(ROW_ID_W), .DIVISOR(ROWS_PER_WORD)) u_word_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (row_done),
        .dividend  (row_rem),
        .done      (word_done),
        .quotient  (word_quo),
        .remainder (word_rem)
    );

    // map a row word that lands past the last whole word to word zero
    assign row_word = (32'(word_quo) >= 32'(WPS)) ? '0 : word_quo;

    bsi_mem #(.DEPTH(DEPTH), .AW(AW), .WIDTH(RPW)) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign cmp_ctrl.clr = accept;
    assign cmp_ctrl.en  = rd_valid_reg && !rd_present_reg;

    bsi_cmp #(.RPW(RPW)) u_cmp_lo (
        .clk       (clk),
        .ctrl      (cmp_ctrl),
        .slice     (mem_rdata),
        .bound_bit (vsh_reg[0]),
        .lt        (lt_lo),
        .gt        (gt_lo)
    );

    bsi_cmp #(.RPW(RPW)) u_cmp_hi (
        .clk       (clk),
        .ctrl      (cmp_ctrl),
        .slice     (mem_rdata),
        .bound_bit (hsh_reg[0]),
        .lt        (lt_hi),
        .gt        (gt_hi)
    );

    assign eq_lo     = ~(lt_lo | gt_lo);
    assign eq_hi     = ~(lt_hi | gt_hi);
    assign filt      = item_reg.filter_empty ? present_reg
                                             : (item_reg.filter_word[RPW-1:0] & present_reg);
    assign slice_bit = |(mem_rdata & rmask_reg);

    always_comb
    begin
        case (item_reg.action)
            ACT_LESS:      qres = filt & (lt_lo | (item_reg.allow_equal ? eq_lo : '0));
            ACT_GREATER:   qres = filt & (gt_lo | (item_reg.allow_equal ? eq_lo : '0));
            ACT_EQUAL:     qres = filt & eq_lo;
            ACT_NOT_EQUAL: qres = present_reg & ~eq_lo;
            ACT_BETWEEN:   qres = filt & (gt_lo | eq_lo) & (lt_hi | eq_hi);
            default:       qres = '0;
        endcase
    end

    always_comb
    begin
        rsp_next = '0;
        case (item_reg.action)
            ACT_PUT, ACT_GET:
            begin
                rsp_next.found      = was_reg;
                rsp_next.read_value = was_reg ? VALUE_W'(old_reg) : '0;
            end
            ACT_REMOVE:
            begin
                rsp_next = '0;
            end
            default:
            begin
                rsp_next.result_word = RESULT_W'(qres);
            end
        endcase
    end

    // store ports: clearing pass, then read-modify-write one slice behind the read
    always_comb
    begin
        mem_re    = (state_reg == ST_RUN);
        mem_raddr = addr_reg;
        mem_we    = 1'b0;
        mem_waddr = wb_addr_reg;
        mem_wdata = mem_rdata;
        if (state_reg == ST_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_cnt_reg;
            mem_wdata = '0;
        end
        else if (rd_valid_reg)
        begin
            if (rd_present_reg)
            begin
                mem_we    = is_put || is_remove;
                mem_wdata = is_put ? (mem_rdata | rmask_reg) : (mem_rdata & ~rmask_reg);
            end
            else if (is_put)
            begin
                mem_we    = 1'b1;
                mem_wdata = vsh_reg[0] ? (mem_rdata | rmask_reg) : (mem_rdata & ~rmask_reg);
            end
            else if (is_remove)
            begin
                mem_we    = vsh_reg[0];
                mem_wdata = mem_rdata & ~rmask_reg;
            end
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        depth_next      = depth_reg;
        clr_cnt_next    = clr_cnt_reg;
        k_next          = k_reg;
        rd_valid_next   = 1'b0;
        rd_present_next = rd_present_reg;
        wb_addr_next    = wb_addr_reg;
        addr_next       = addr_reg;
        item_next       = item_reg;
        rmask_next      = rmask_reg;
        vsh_next        = vsh_reg;
        hsh_next        = hsh_reg;
        pos_next        = pos_reg;
        old_next        = old_reg;
        was_next        = was_reg;
        present_next    = present_reg;
        rsp_valid_next  = rsp_valid_reg && rsp_stall;

        if (cfg_we)
        begin
            if (cfg_data == '0)
            begin
                depth_next = DEPW'(1);
            end
            else if (cfg_data > DEPTH_W'(MAX_VALUE_BITS))
            begin
                depth_next = DEPW'(MAX_VALUE_BITS);
            end
            else
            begin
                depth_next = DEPW'(cfg_data);
            end
        end

        if (rd_valid_reg)
        begin
            if (rd_present_reg)
            begin
                was_next     = slice_bit;
                present_next = mem_rdata;
            end
            else
            begin
                old_next = old_reg | (slice_bit ? pos_reg : '0);
                pos_next = pos_reg << 1;
                vsh_next = vsh_reg >> 1;
                hsh_next = hsh_reg >> 1;
            end
        end

        case (state_reg)
            ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == AW'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    item_next  = req;
                    vsh_next   = req.value[MVB-1:0];
                    hsh_next   = req.value_high[MVB-1:0];
                    pos_next   = MVB'(1);
                    old_next   = '0;
                    state_next = ST_DIV_A;
                end
            end
            ST_DIV_A:
            begin
                if (row_done)
                begin
                    state_next = ST_DIV_B;
                end
            end
            ST_DIV_B:
            begin
                if (word_done)
                begin
                    rmask_next = RPW'(1) << word_rem[RBW-1:0];
                    addr_next  = is_row_op ? AW'(row_word) : AW'(widx_rem);
                    k_next     = '0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                rd_valid_next   = 1'b1;
                rd_present_next = (k_reg == '0);
                wb_addr_next    = addr_reg;
                addr_next       = addr_reg + AW'(WPS);
                k_next          = k_reg + DEPW'(1);
                if (k_reg == depth_reg)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            depth_reg     <= DEPW'(MAX_VALUE_BITS);
            clr_cnt_reg   <= '0;
            k_reg         <= '0;
            rd_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            depth_reg     <= depth_next;
            clr_cnt_reg   <= clr_cnt_next;
            k_reg         <= k_next;
            rd_valid_reg  <= rd_valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg       <= item_next;
        addr_reg       <= addr_next;
        wb_addr_reg    <= wb_addr_next;
        rd_present_reg <= rd_present_next;
        rmask_reg      <= rmask_next;
        vsh_reg        <= vsh_next;
        hsh_reg        <= hsh_next;
        pos_reg        <= pos_next;
        old_reg        <= old_next;
        was_reg        <= was_next;
        present_reg    <= present_next;
        if ((state_reg == ST_FIN) && rsp_free)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule
